// File: rtl/eac_pkg.sv
package eac_pkg;

	localparam int unsigned CH_W    = 8;
	localparam int unsigned CNT_W   = 9;
	localparam int unsigned LEN_W   = 8;
	localparam int unsigned CFG_IDX_W = 1;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	localparam logic [LEN_W-1:0] MAX_TOTAL_RST = 8'd255;
	localparam logic [LEN_W-1:0] MAX_LOCAL_RST = 8'd64;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_TOTAL = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LOCAL = 1'd1;

	localparam logic [CH_W-1:0] CH_AT    = 8'h40;
	localparam logic [CH_W-1:0] CH_DOT   = 8'h2e;
	localparam logic [CH_W-1:0] CH_UNDER = 8'h5f;
	localparam logic [CH_W-1:0] CH_DASH  = 8'h2d;

	typedef enum logic [2:0] {
		RSN_OK        = 3'd0,
		RSN_TOO_LONG  = 3'd1,
		RSN_NO_AT     = 3'd2,
		RSN_LOCAL_LEN = 3'd3,
		RSN_LOCAL_CH  = 3'd4,
		RSN_DOM_EMPTY = 3'd5,
		RSN_NO_DOT    = 3'd6,
		RSN_TLD_SUB   = 3'd7
	} reason_t;

	typedef struct packed {
		logic           bad_subdomain;
		reason_t        reason;
		logic           valid_res;
	} result_t;

	function automatic logic is_alnum(input logic [CH_W-1:0] c);
		return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) ||
			(c >= 8'h30 && c <= 8'h39);
	endfunction

	function automatic logic ok_local(input logic [CH_W-1:0] c);
		return is_alnum(c) || c == CH_DOT || c == CH_UNDER || c == CH_DASH;
	endfunction

	function automatic logic ok_sub(input logic [CH_W-1:0] c);
		return is_alnum(c) || c == CH_DOT || c == CH_DASH;
	endfunction

endpackage

// File: rtl/email_address_checker.sv
// Email address syntax checker.
// Input stream (s_*): one address byte per request, s_tlast on its final byte.
// Output stream (m_*): one verdict per address, issued for the final byte only.
// Configuration: cfg_we writes cfg_data into register cfg_idx (0: max total
// length, 1: max local length); write only while no address is in flight.
// Throughput: one byte per cycle while s_tready is high. Each non-final byte
// updates the per-address counters and flags in the same cycle it is accepted;
// the final byte clears them. The verdict is formed from the updated values and
// lands in the output register, appearing on m_tvalid in the cycle after the
// final byte is accepted.
// Stall: the output register holds its verdict while m_tready is low; bytes
// that are not final keep flowing, and s_tready drops only when a final byte
// would need the occupied output register.
// Reset: arst_n clears the per-address state and the output valid, and
// restores the length limits to 255 and 64.
module email_address_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] ch
	input  logic       s_tlast,   // last_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [0] valid_res, [3:1] reason, [4] bad_subdomain, [7:5] zero
	input  logic       cfg_we,
	input  logic [eac_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [eac_pkg::LEN_W-1:0]     cfg_data
);

	logic [eac_pkg::LEN_W-1:0] max_total_q, max_local_q;
	logic [eac_pkg::CNT_W-1:0] total_q, local_q, total_n, local_n;
	logic in_dom_q, dom_ne_q, local_bad_q, sub_bad_q, pend_q, dot_q, tld_ne_q;
	logic in_dom_n, dom_ne_n, local_bad_n, sub_bad_n, pend_n, dot_n, tld_ne_n;
	logic accept, out_free;
	eac_pkg::result_t res, res_q;
	logic res_valid_q;

	// a non-final byte never needs the output register
	assign out_free = !res_valid_q || m_tready;
	assign s_tready = out_free || !s_tlast;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		total_n     = (total_q == eac_pkg::CNT_MAX) ? total_q : total_q + 1'b1;
		local_n     = local_q;
		in_dom_n    = in_dom_q;
		dom_ne_n    = dom_ne_q;
		local_bad_n = local_bad_q;
		sub_bad_n   = sub_bad_q;
		pend_n      = pend_q;
		dot_n       = dot_q;
		tld_ne_n    = tld_ne_q;
		if (!in_dom_q) begin
			if (s_tdata == eac_pkg::CH_AT) begin
				in_dom_n = 1'b1;
			end else begin
				if (local_q != eac_pkg::CNT_MAX)
					local_n = local_q + 1'b1;
				if (!eac_pkg::ok_local(s_tdata))
					local_bad_n = 1'b1;
			end
		end else begin
			dom_ne_n = 1'b1;
			if (s_tdata == eac_pkg::CH_DOT) begin
				// commit any bad byte seen since the previous dot
				dot_n     = 1'b1;
				tld_ne_n  = 1'b0;
				sub_bad_n = sub_bad_q || pend_q;
				pend_n    = 1'b0;
			end else begin
				tld_ne_n = 1'b1;
				if (!eac_pkg::ok_sub(s_tdata))
					pend_n = 1'b1;
			end
		end
	end

	always_comb begin
		res.bad_subdomain = 1'b0;
		priority if (total_n > {1'b0, max_total_q})
			res.reason = eac_pkg::RSN_TOO_LONG;
		else if (!in_dom_n)
			res.reason = eac_pkg::RSN_NO_AT;
		else if (local_n == '0 || local_n > {1'b0, max_local_q})
			res.reason = eac_pkg::RSN_LOCAL_LEN;
		else if (local_bad_n)
			res.reason = eac_pkg::RSN_LOCAL_CH;
		else if (!dom_ne_n)
			res.reason = eac_pkg::RSN_DOM_EMPTY;
		else if (!dot_n)
			res.reason = eac_pkg::RSN_NO_DOT;
		else if (!tld_ne_n)
			res.reason = eac_pkg::RSN_TLD_SUB;
		else if (sub_bad_n) begin
			res.reason        = eac_pkg::RSN_TLD_SUB;
			res.bad_subdomain = 1'b1;
		end else
			res.reason = eac_pkg::RSN_OK;
		res.valid_res = (res.reason == eac_pkg::RSN_OK);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_total_q <= eac_pkg::MAX_TOTAL_RST;
			max_local_q <= eac_pkg::MAX_LOCAL_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				eac_pkg::REG_MAX_TOTAL: max_total_q <= cfg_data;
				eac_pkg::REG_MAX_LOCAL: max_local_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= '0;
			local_q     <= '0;
			in_dom_q    <= 1'b0;
			dom_ne_q    <= 1'b0;
			local_bad_q <= 1'b0;
			sub_bad_q   <= 1'b0;
			pend_q      <= 1'b0;
			dot_q       <= 1'b0;
			tld_ne_q    <= 1'b0;
		end else if (accept) begin
			if (s_tlast) begin
				total_q     <= '0;
				local_q     <= '0;
				in_dom_q    <= 1'b0;
				dom_ne_q    <= 1'b0;
				local_bad_q <= 1'b0;
				sub_bad_q   <= 1'b0;
				pend_q      <= 1'b0;
				dot_q       <= 1'b0;
				tld_ne_q    <= 1'b0;
			end else begin
				total_q     <= total_n;
				local_q     <= local_n;
				in_dom_q    <= in_dom_n;
				dom_ne_q    <= dom_ne_n;
				local_bad_q <= local_bad_n;
				sub_bad_q   <= sub_bad_n;
				pend_q      <= pend_n;
				dot_q       <= dot_n;
				tld_ne_q    <= tld_ne_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept && s_tlast) begin
			res_valid_q <= 1'b1;
		end else if (m_tready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && s_tlast)
			res_q <= res;
	end

	assign m_tvalid = res_valid_q;
	assign m_tdata  = {3'b000, res_q};

	a_verdict_matches_reason: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[0] == (m_tdata[3:1] == eac_pkg::RSN_OK)))
		else $error("verdict disagrees with reason code");

	a_badsub_only_rsn7: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[4]) |-> (m_tdata[3:1] == eac_pkg::RSN_TLD_SUB))
		else $error("bad_subdomain set with another reason");

	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tlast) |=> m_tvalid)
		else $error("final byte accepted but no verdict pending");

	a_state_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tlast) |=> (total_q == '0 && local_q == '0 && !in_dom_q && !pend_q))
		else $error("per-address state not cleared after final byte");

	a_local_le_total: assert property (@(posedge clk) disable iff (!arst_n)
		local_q <= total_q)
		else $error("local count exceeds total count");

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam int DIR_N    = 28;
	localparam int FIXED_PH = 7;
	localparam int N_PH     = 9;
	localparam int PH_BYTES = 22;
	localparam int LONG_PH  = 2;

	typedef struct packed {
		logic [7:0]       ch;
		logic             fin;
		logic             typed;
		eac_pkg::reason_t rsn;
		logic             bad_sub;
	} dir_row_t;

	logic                          clk;
	logic                          arst_n;
	logic                          s_tvalid;
	logic                          s_tready;
	logic [7:0]                    s_tdata;
	logic                          s_tlast;
	logic                          m_tvalid;
	logic                          m_tready;
	logic [7:0]                    m_tdata;
	logic                          cfg_we;
	logic [eac_pkg::CFG_IDX_W-1:0] cfg_idx;
	logic [eac_pkg::LEN_W-1:0]     cfg_data;

	// shadow of the per-address state and the limits
	logic [eac_pkg::CNT_W-1:0] n_total = '0;
	logic [eac_pkg::CNT_W-1:0] n_local = '0;
	logic in_dom = 1'b0, dom_any = 1'b0, loc_bad = 1'b0, sub_bad = 1'b0;
	logic pend_bad = 1'b0, dot_any = 1'b0, tld_any = 1'b0;
	logic [eac_pkg::LEN_W-1:0] lim_total = 8'd255;
	logic [eac_pkg::LEN_W-1:0] lim_local = 8'd64;

	eac_pkg::result_t verdict_q [$];
	logic [7:0]       addr_bytes [$];
	int               mismatches = 0;
	logic             quiet = 1'b0;
	logic             row_typed = 1'b0;
	eac_pkg::result_t row_res = '0;

	int ph_total [FIXED_PH] = '{255, 1, 255, 12, 30, 255, 8};
	int ph_local [FIXED_PH] = '{64, 1, 255, 4, 10, 1, 255};

	dir_row_t dir_tab [DIR_N] = '{
		'{"a", 1'b0, 1'b0, eac_pkg::RSN_OK, 1'b0},
		'{eac_pkg::CH_AT, 1'b0, 1'b0, eac_pkg::RSN_OK, 1'b0},
		'{"b", 1'b0, 1'b0, eac_pkg::RSN_OK, 1'b0},
		'{eac_pkg::CH_DOT, 1'b0, 1'b0, eac_pkg::RSN_OK, 1'b0},
		'{"c", 1'b1, 1'b1, eac_pkg::RSN_OK, 1'b0},
		'{eac_pkg::CH_AT, 1'b1, 1'b1, eac_pkg::RSN_LOCAL_LEN, 1'b0},
		'{8'h00, 1'b1, 1'b1, eac_pkg::RSN_NO_AT, 1'b0},
		'{8'hff, 1'b0, 1'b0, eac_pkg::RSN_OK, 1'b0},
		'{eac_pkg::CH_AT, 1'b1, 1'b1, eac_pkg::RSN_LOCAL_CH, 1'b0},
		'{"Z", 1'b0, 1'b0, eac_pkg::RSN_OK, 1'b0},
		'{eac_pkg::CH_AT, 1'b1, 1'b1, eac_pkg::RSN_DOM_EMPTY, 1'b0},
		'{"9", 1'b0, 1'b0, eac_pkg::RSN_OK, 1'b0},
		'{eac_pkg::CH_AT, 1'b0, 1'b0, eac_pkg::RSN_OK, 1'b0},
		'{eac_pkg::CH_DASH, 1'b1, 1'b1, eac_pkg::RSN_NO_DOT, 1'b0},
		'{eac_pkg::CH_UNDER, 1'b0, 1'b0, eac_pkg::RSN_OK, 1'b0},
		'{eac_pkg::CH_AT, 1'b0, 1'b0, eac_pkg::RSN_OK, 1'b0},
		'{"x", 1'b0, 1'b0, eac_pkg::RSN_OK, 1'b0},
		'{eac_pkg::CH_DOT, 1'b1, 1'b1, eac_pkg::RSN_TLD_SUB, 1'b0},
		'{"a", 1'b0, 1'b0, eac_pkg::RSN_OK, 1'b0},
		'{eac_pkg::CH_AT, 1'b0, 1'b0, eac_pkg::RSN_OK, 1'b0},
		'{eac_pkg::CH_UNDER, 1'b0, 1'b0, eac_pkg::RSN_OK, 1'b0},
		'{eac_pkg::CH_DOT, 1'b0, 1'b0, eac_pkg::RSN_OK, 1'b0},
		'{8'hff, 1'b1, 1'b1, eac_pkg::RSN_TLD_SUB, 1'b1},
		'{eac_pkg::CH_DASH, 1'b0, 1'b0, eac_pkg::RSN_OK, 1'b0},
		'{eac_pkg::CH_AT, 1'b0, 1'b0, eac_pkg::RSN_OK, 1'b0},
		'{eac_pkg::CH_AT, 1'b0, 1'b0, eac_pkg::RSN_OK, 1'b0},
		'{eac_pkg::CH_DOT, 1'b0, 1'b0, eac_pkg::RSN_OK, 1'b0},
		'{"x", 1'b1, 1'b0, eac_pkg::RSN_OK, 1'b0}
	};

	email_address_checker dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("email_address_checker verification failed");
		$finish;
	end

	function automatic logic letter_or_digit(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9");
	endfunction

	function automatic logic local_ok(input logic [7:0] c);
		return letter_or_digit(c) || c == eac_pkg::CH_DOT || c == eac_pkg::CH_UNDER ||
			c == eac_pkg::CH_DASH;
	endfunction

	function automatic logic label_ok(input logic [7:0] c);
		return letter_or_digit(c) || c == eac_pkg::CH_DOT || c == eac_pkg::CH_DASH;
	endfunction

	// advance the address state by one byte; return 1 with the verdict on the final byte
	function automatic logic score_byte(input logic [7:0] c, input logic fin,
			output eac_pkg::result_t v);
		eac_pkg::reason_t why;
		logic             bad;
		why = eac_pkg::RSN_OK;
		bad = 1'b0;
		v = '0;
		if (n_total != eac_pkg::CNT_MAX)
			n_total = n_total + 1'b1;
		if (!in_dom) begin
			if (c == eac_pkg::CH_AT) begin
				in_dom = 1'b1;
			end else begin
				if (n_local != eac_pkg::CNT_MAX)
					n_local = n_local + 1'b1;
				if (!local_ok(c))
					loc_bad = 1'b1;
			end
		end else begin
			dom_any = 1'b1;
			if (c == eac_pkg::CH_DOT) begin
				// commit a bad byte held since the previous dot
				dot_any = 1'b1;
				tld_any = 1'b0;
				sub_bad = sub_bad | pend_bad;
				pend_bad = 1'b0;
			end else begin
				tld_any = 1'b1;
				if (!label_ok(c))
					pend_bad = 1'b1;
			end
		end
		if (!fin)
			return 1'b0;
		if (n_total > lim_total)
			why = eac_pkg::RSN_TOO_LONG;
		else if (!in_dom)
			why = eac_pkg::RSN_NO_AT;
		else if (n_local == 0 || n_local > lim_local)
			why = eac_pkg::RSN_LOCAL_LEN;
		else if (loc_bad)
			why = eac_pkg::RSN_LOCAL_CH;
		else if (!dom_any)
			why = eac_pkg::RSN_DOM_EMPTY;
		else if (!dot_any)
			why = eac_pkg::RSN_NO_DOT;
		else if (!tld_any)
			why = eac_pkg::RSN_TLD_SUB;
		else if (sub_bad) begin
			why = eac_pkg::RSN_TLD_SUB;
			bad = 1'b1;
		end
		v.valid_res = (why == eac_pkg::RSN_OK);
		v.reason = why;
		v.bad_subdomain = bad;
		n_total = '0;
		n_local = '0;
		{in_dom, dom_any, loc_bad, sub_bad, pend_bad, dot_any, tld_any} = '0;
		return 1'b1;
	endfunction

	task automatic log_mismatch(input string why, input eac_pkg::result_t want,
			input eac_pkg::result_t got);
		mismatches++;
		if (mismatches <= 10)
			$display({"mismatch (%s): expected valid=%0b reason=%0d bad_sub=%0b, ",
				"got valid=%0b reason=%0d bad_sub=%0b"},
				why, want.valid_res, want.reason, want.bad_subdomain,
				got.valid_res, got.reason, got.bad_subdomain);
	endtask

	always @(posedge clk) begin : check_and_predict
		eac_pkg::result_t got, want;
		if (m_tvalid && m_tready) begin
			got = m_tdata[4:0];
			if (verdict_q.size() == 0) begin
				log_mismatch("no verdict pending", '0, got);
			end else begin
				want = verdict_q.pop_front();
				if (got.valid_res !== want.valid_res || got.reason !== want.reason ||
						got.bad_subdomain !== want.bad_subdomain)
					log_mismatch("verdict", want, got);
			end
		end
		if (cfg_we) begin
			case (cfg_idx)
				eac_pkg::REG_MAX_TOTAL: lim_total = cfg_data;
				eac_pkg::REG_MAX_LOCAL: lim_local = cfg_data;
				default: ;
			endcase
		end
		if (s_tvalid && s_tready) begin
			if (score_byte(s_tdata, s_tlast, want))
				verdict_q.push_back(row_typed ? row_res : want);
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	initial begin
		int rdy_hold;
		rdy_hold = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (rdy_hold == 0) begin
				if (quiet || $urandom_range(0, 3) != 0) begin
					m_tready <= 1'b1;
					rdy_hold = quiet ? 1 : $urandom_range(1, 6);
				end else begin
					m_tready <= 1'b0;
					rdy_hold = gap_len() + 1;
				end
			end
			rdy_hold--;
		end
	end

	// returns at the rising edge that accepts the request
	task automatic send_byte(input logic [7:0] c, input logic fin, input logic typed,
			input eac_pkg::reason_t rsn, input logic bad);
		int gap;
		gap = gap_len();
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		row_typed = typed;
		row_res.valid_res = (rsn == eac_pkg::RSN_OK);
		row_res.reason = rsn;
		row_res.bad_subdomain = bad;
		s_tvalid <= 1'b1;
		s_tdata <= c;
		s_tlast <= fin;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_address();
		foreach (addr_bytes[i])
			send_byte(addr_bytes[i], i == addr_bytes.size() - 1, 1'b0, eac_pkg::RSN_OK, 1'b0);
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (verdict_q.size() != 0) @(negedge clk);
	endtask

	task automatic write_limits(input int tot, input int loc);
		drain();
		repeat (4) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= eac_pkg::REG_MAX_TOTAL;
		cfg_data <= tot[eac_pkg::LEN_W-1:0];
		@(negedge clk);
		cfg_idx <= eac_pkg::REG_MAX_LOCAL;
		cfg_data <= loc[eac_pkg::LEN_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// letters and digits, then dash, then dot and underscore for the local part
	function automatic logic [7:0] word_ch(input logic for_local);
		int r;
		r = $urandom_range(0, for_local ? 64 : 62);
		if (r < 26)
			return 8'(8'h61 + r);
		if (r < 52)
			return 8'(8'h41 + r - 26);
		if (r < 62)
			return 8'(8'h30 + r - 52);
		if (r == 62)
			return eac_pkg::CH_DASH;
		return (r == 63) ? eac_pkg::CH_DOT : eac_pkg::CH_UNDER;
	endfunction

	task automatic make_address();
		int r, n, labels, ll;
		addr_bytes.delete();
		ll = int'(lim_local);
		r = $urandom_range(0, 99);
		if (r < 12) begin
			n = $urandom_range(1, 12);
			repeat (n) begin
				r = $urandom_range(0, 7);
				addr_bytes.push_back(r == 0 ? eac_pkg::CH_AT :
					r == 1 ? eac_pkg::CH_DOT : 8'($urandom_range(0, 255)));
			end
			return;
		end
		r = $urandom_range(0, 99);
		if (r < 80)
			n = $urandom_range(1, 8);
		else if (r < 93 && ll <= 70)
			n = $urandom_range(ll - 1, ll + 1);
		else if (r < 96)
			n = 0;
		else
			n = $urandom_range(1, 8);
		repeat (n)
			addr_bytes.push_back($urandom_range(0, 19) == 0 ?
				8'($urandom_range(0, 255)) : word_ch(1'b1));
		if ($urandom_range(0, 19) != 0)
			addr_bytes.push_back(eac_pkg::CH_AT);
		labels = ($urandom_range(0, 99) < 70) ? 1 : $urandom_range(0, 3);
		for (int k = 0; k < labels; k++) begin
			if (k > 0)
				addr_bytes.push_back(eac_pkg::CH_DOT);
			n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
			repeat (n)
				addr_bytes.push_back($urandom_range(0, 14) == 0 ?
					8'($urandom_range(0, 255)) : word_ch(1'b0));
		end
		r = $urandom_range(0, 99);
		if (r < 82) begin
			addr_bytes.push_back(eac_pkg::CH_DOT);
			n = $urandom_range(1, 4);
			repeat (n)
				addr_bytes.push_back($urandom_range(0, 3) == 0 ?
					8'($urandom_range(0, 255)) : word_ch(1'b0));
		end else if (r < 90) begin
			addr_bytes.push_back(eac_pkg::CH_DOT);
		end
		if (addr_bytes.size() == 0)
			addr_bytes.push_back(word_ch(1'b1));
	endtask

	initial begin
		int tot, loc, sent;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = eac_pkg::REG_MAX_TOTAL;
		cfg_data = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_tab[i])
			send_byte(dir_tab[i].ch, dir_tab[i].fin, dir_tab[i].typed, dir_tab[i].rsn,
				dir_tab[i].bad_sub);

		for (int ph = 0; ph < N_PH; ph++) begin
			if (ph < FIXED_PH) begin
				tot = ph_total[ph];
				loc = ph_local[ph];
			end else begin
				tot = $urandom_range(1, 255);
				loc = $urandom_range(1, 255);
			end
			write_limits(tot, loc);
			quiet = (ph % 3 == 2);
			if (ph == LONG_PH) begin
				// one byte over the largest total limit, so only a 9-bit count catches it
				addr_bytes.delete();
				repeat (252) addr_bytes.push_back("q");
				addr_bytes.push_back(eac_pkg::CH_AT);
				addr_bytes.push_back("a");
				addr_bytes.push_back(eac_pkg::CH_DOT);
				addr_bytes.push_back("b");
				send_address();
			end
			sent = 0;
			while (sent < PH_BYTES) begin
				make_address();
				send_address();
				sent += addr_bytes.size();
				if ($urandom_range(0, 24) == 0)
					drain();
			end
		end

		drain();
		repeat (10) @(posedge clk);
		if (verdict_q.size() != 0) begin
			$display("%0d verdicts never arrived", verdict_q.size());
			mismatches += verdict_q.size();
		end
		if (mismatches == 0)
			$display("email_address_checker verification clean");
		else
			$display("email_address_checker verification failed");
		$finish;
	end

endmodule

// File: email_address_checker.f
rtl/eac_pkg.sv
rtl/email_address_checker.sv
test/testbench.sv
